/* hw/rtl/tti_pkg.sv */
// ----------------------------------------------------------------------------
// tti_pkg
// Shared constants, types and helpers for the thermistor table interpolator.
// ----------------------------------------------------------------------------
package tti_pkg;

   localparam int unsigned ROM_SIZE          = 111;
   localparam int unsigned ROM_ADDR_W        = $clog2(ROM_SIZE);
   localparam int unsigned TABLE_ENTRIES_DEF = 111;
   localparam int unsigned FRACTION_BITS_DEF = 8;
   localparam int          FIRST_DEGREE      = -25;
   localparam logic [15:0] VOLTAGE_LIMIT     = 16'd33000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_HIGH = 2'd1,
      STATUS_LOW  = 2'd2
   } status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Whole degree of table row idx in fixed point, wrapped to 16 bits.
   function automatic logic [15:0] deg_fixed(logic [7:0] idx, int unsigned fb);
      logic [15:0] d;
      d = 16'(FIRST_DEGREE) + 16'(idx);
      return d << fb;
   endfunction

endpackage

/* hw/rtl/tti_rom.sv */
// ----------------------------------------------------------------------------
// tti_rom
// Voltage table, one entry per degree from -25 to 85 C, falling order.
// Synchronous read: the data is registered and valid the cycle after the address.
// ----------------------------------------------------------------------------
module tti_rom #(
   parameter int unsigned ADDR_W = tti_pkg::ROM_ADDR_W
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   localparam logic [15:0] VOLTS [tti_pkg::ROM_SIZE] = '{
      16'd31038, 16'd30915, 16'd30787, 16'd30652, 16'd30510, 16'd30362,
      16'd30207, 16'd30045, 16'd29875, 16'd29698, 16'd29514, 16'd29322,
      16'd29121, 16'd28913, 16'd28697, 16'd28473, 16'd28240, 16'd27999,
      16'd27750, 16'd27493, 16'd27227, 16'd26954, 16'd26672, 16'd26382,
      16'd26085, 16'd25779, 16'd25466, 16'd25145, 16'd24817, 16'd24482,
      16'd24141, 16'd23793, 16'd23439, 16'd23080, 16'd22715, 16'd22345,
      16'd21970, 16'd21592, 16'd21210, 16'd20824, 16'd20436, 16'd20045,
      16'd19652, 16'd19258, 16'd18863, 16'd18468, 16'd18072, 16'd17677,
      16'd17283, 16'd16891, 16'd16500, 16'd16111, 16'd15725, 16'd15342,
      16'd14963, 16'd14587, 16'd14215, 16'd13848, 16'd13485, 16'd13128,
      16'd12775, 16'd12428, 16'd12087, 16'd11752, 16'd11422, 16'd11099,
      16'd10782, 16'd10472, 16'd10168, 16'd9870,  16'd9580,  16'd9295,
      16'd9018,  16'd8747,  16'd8482,  16'd8224,  16'd7973,  16'd7729,
      16'd7491,  16'd7259,  16'd7034,  16'd6815,  16'd6603,  16'd6396,
      16'd6195,  16'd6000,  16'd5811,  16'd5628,  16'd5450,  16'd5277,
      16'd5110,  16'd4948,  16'd4792,  16'd4640,  16'd4493,  16'd4350,
      16'd4212,  16'd4078,  16'd3949,  16'd3823,  16'd3702,  16'd3585,
      16'd3472,  16'd3362,  16'd3256,  16'd3153,  16'd3054,  16'd2958,
      16'd2866,  16'd2776,  16'd2689
   };

   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= VOLTS[tti_pkg::ROM_ADDR_W'(rd_addr)];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/tti_div.sv */
// ----------------------------------------------------------------------------
// tti_div
// Restoring fraction divider: (rem0 << FRAC_BITS) / divisor, rem0 < divisor.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tti_div #(
   parameter int unsigned FRAC_BITS = tti_pkg::FRACTION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [15:0]                  rem0,
   input  logic [15:0]                  divisor,
   output tti_pkg::div_status_type      status,
   output logic [((FRAC_BITS > 0) ? FRAC_BITS : 1)-1:0] quotient
);

   localparam int unsigned QW    = (FRAC_BITS > 0) ? FRAC_BITS : 1;
   localparam int unsigned CNT_W = $clog2(FRAC_BITS + 2);

   logic             run_ff,  run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic [15:0]      rem_ff,  rem_in;
   logic [15:0]      dvs_ff,  dvs_in;
   logic [QW-1:0]    q_ff,    q_in;
   logic [16:0]      rem2;
   logic             take;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      rem2    = {rem_ff, 1'b0};
      take    = rem2 >= {1'b0, dvs_ff};
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(FRAC_BITS);
         rem_in = rem0;
         dvs_in = divisor;
         q_in   = '0;
      end else if (run_ff) begin
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
            rem_in = take ? 16'(rem2 - {1'b0, dvs_ff}) : rem2[15:0];
            q_in   = QW'({q_ff, take});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

/* hw/rtl/thermistor_table_interpolator.sv */
// From request to result: one ROM read per entry during the search,
// then the divider works out the fraction bits. One request in flight
// at a time, and the ROM search dominates the time per request.
// Reset: synchronous, clears the control state; the ROM needs no clearing.
// ----------------------------------------------------------------------------
// thermistor_table_interpolator
// Voltage to temperature by linear interpolation over a voltage table.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator #(
   parameter int unsigned TABLE_ENTRIES = tti_pkg::TABLE_ENTRIES_DEF,
   parameter int unsigned FRACTION_BITS = tti_pkg::FRACTION_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [15:0]        req_voltage,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_temperature,
   output logic [1:0]         rsp_status
);

   localparam int unsigned USED  = (TABLE_ENTRIES < tti_pkg::ROM_SIZE) ?
                                   TABLE_ENTRIES : tti_pkg::ROM_SIZE;
   localparam int unsigned IDX_W = $clog2(USED);
   localparam int unsigned QW    = (FRACTION_BITS > 0) ? FRACTION_BITS : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(USED - 1);

   tti_pkg::state_type      state_ff, state_in;
   tti_pkg::status_type     status_ff, status_in;
   tti_pkg::status_type     rsp_status_ff, rsp_status_in;
   logic [15:0]             volt_ff, volt_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        seg_ff, seg_in;
   logic [15:0]             prev_ff, prev_in;
   logic [15:0]             temp_ff, temp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_temperature_ff, rsp_temperature_in;

   logic [IDX_W-1:0]        rd_addr;
   logic [15:0]             rd_data;
   logic                    found;
   logic                    out_free;
   logic                    div_start;
   logic [15:0]             div_rem0;
   logic [15:0]             div_divisor;
   tti_pkg::div_status_type div_st;
   logic [QW-1:0]           div_q;

   tti_rom #(
      .ADDR_W (tti_pkg::ROM_ADDR_W)
   ) u_rom (
      .clock   (clock),
      .rd_addr (tti_pkg::ROM_ADDR_W'(rd_addr)),
      .rd_data (rd_data)
   );

   tti_div #(
      .FRAC_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem0     (div_rem0),
      .divisor  (div_divisor),
      .status   (div_st),
      .quotient (div_q)
   );

   assign found    = rd_data <= volt_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Prefetch the next entry so the search compares one entry per cycle.
   always_comb begin
      if (state_ff == tti_pkg::ST_IDLE) begin
         rd_addr = '0;
      end else if (idx_ff == LAST) begin
         rd_addr = idx_ff;
      end else begin
         rd_addr = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      state_in           = state_ff;
      status_in          = status_ff;
      volt_in            = volt_ff;
      idx_in             = idx_ff;
      seg_in             = seg_ff;
      prev_in            = prev_ff;
      temp_in            = temp_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_temperature_in = rsp_temperature_ff;
      rsp_status_in      = rsp_status_ff;
      div_start          = 1'b0;
      div_rem0           = prev_ff - volt_ff;
      div_divisor        = prev_ff - rd_data;
      unique case (state_ff)
         tti_pkg::ST_IDLE: begin
            if (req_valid) begin
               volt_in = req_voltage;
               idx_in  = '0;
               if (req_voltage > tti_pkg::VOLTAGE_LIMIT) begin
                  temp_in   = '0;
                  status_in = tti_pkg::STATUS_HIGH;
                  state_in  = tti_pkg::ST_FINISH;
               end else begin
                  state_in = tti_pkg::ST_SEARCH;
               end
            end
         end
         tti_pkg::ST_SEARCH: begin
            if (found) begin
               if (idx_ff == '0) begin
                  temp_in   = tti_pkg::deg_fixed(8'd0, FRACTION_BITS);
                  status_in = tti_pkg::STATUS_OK;
                  state_in  = tti_pkg::ST_FINISH;
               end else if (rd_data == volt_ff) begin
                  // input sits on the entry: a full degree, no divide
                  temp_in   = tti_pkg::deg_fixed(8'(idx_ff), FRACTION_BITS);
                  status_in = tti_pkg::STATUS_OK;
                  state_in  = tti_pkg::ST_FINISH;
               end else begin
                  seg_in    = idx_ff - IDX_W'(1);
                  div_start = 1'b1;
                  state_in  = tti_pkg::ST_DIVIDE;
               end
            end else if (idx_ff == LAST) begin
               temp_in   = '0;
               status_in = tti_pkg::STATUS_LOW;
               state_in  = tti_pkg::ST_FINISH;
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               prev_in = rd_data;
            end
         end
         tti_pkg::ST_DIVIDE: begin
            if (div_st.done) begin
               temp_in   = tti_pkg::deg_fixed(8'(seg_ff), FRACTION_BITS)
                           + 16'(div_q);
               status_in = tti_pkg::STATUS_OK;
               state_in  = tti_pkg::ST_FINISH;
            end
         end
         tti_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_temperature_in = temp_ff;
               rsp_status_in      = status_ff;
               state_in           = tti_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tti_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tti_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff          <= status_in;
      volt_ff            <= volt_in;
      idx_ff             <= idx_in;
      seg_ff             <= seg_in;
      prev_ff            <= prev_in;
      temp_ff            <= temp_in;
      rsp_temperature_ff <= rsp_temperature_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign req_stall       = state_ff != tti_pkg::ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = $signed(rsp_temperature_ff);
   assign rsp_status      = rsp_status_ff;

   // One request in flight: the block stalls right after taking one.
   a_single_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while another is in flight");

   // A segment handed to the divider always has a nonzero span.
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (prev_ff > rd_data) && (prev_ff >= volt_ff))
      else $error("divider started on an empty or inverted segment");

   // Divider completion only while the sequencer waits for it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_st.done |-> state_ff == tti_pkg::ST_DIVIDE)
      else $error("divider finished outside the divide phase");

   // An error result always carries a zero temperature.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != tti_pkg::STATUS_OK) |-> rsp_temperature == 16'sd0)
      else $error("error result with nonzero temperature");

endmodule

/* tb/sv/thermistor_table_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// thermistor_table_interpolator_tb
// Self-checking bench: drives voltage requests with random gaps, stalls the
// result side at random (with one long hold-off so the block backs up), and
// compares every temperature and status against an interpolation predictor.
// ----------------------------------------------------------------------------
module thermistor_table_interpolator_tb;

   localparam int unsigned USED_ENTRIES =
      (tti_pkg::TABLE_ENTRIES_DEF < tti_pkg::ROM_SIZE) ?
      tti_pkg::TABLE_ENTRIES_DEF : tti_pkg::ROM_SIZE;
   localparam int unsigned FRAC_BITS   = tti_pkg::FRACTION_BITS_DEF;
   localparam int unsigned RANDOM_REQS = 400;
   localparam int unsigned IDLE_LIMIT  = 4000;
   localparam int unsigned HOLD_CYCLES = 600;
   localparam int unsigned TAIL_CYCLES = 200;
   localparam int unsigned MAX_PRINTS  = 40;

   typedef struct {
      logic [15:0]         voltage;
      logic signed [15:0]  temperature;
      tti_pkg::status_type status;
   } reading_type;

   class temperature_checker;
      logic [15:0] volt_table [tti_pkg::ROM_SIZE];
      reading_type pending_readings [$];
      int unsigned mismatches;

      function new();
         volt_table = '{
            31038, 30915, 30787, 30652, 30510, 30362, 30207, 30045, 29875, 29698,
            29514, 29322, 29121, 28913, 28697, 28473, 28240, 27999, 27750, 27493,
            27227, 26954, 26672, 26382, 26085, 25779, 25466, 25145, 24817, 24482,
            24141, 23793, 23439, 23080, 22715, 22345, 21970, 21592, 21210, 20824,
            20436, 20045, 19652, 19258, 18863, 18468, 18072, 17677, 17283, 16891,
            16500, 16111, 15725, 15342, 14963, 14587, 14215, 13848, 13485, 13128,
            12775, 12428, 12087, 11752, 11422, 11099, 10782, 10472, 10168,  9870,
             9580,  9295,  9018,  8747,  8482,  8224,  7973,  7729,  7491,  7259,
             7034,  6815,  6603,  6396,  6195,  6000,  5811,  5628,  5450,  5277,
             5110,  4948,  4792,  4640,  4493,  4350,  4212,  4078,  3949,  3823,
             3702,  3585,  3472,  3362,  3256,  3153,  3054,  2958,  2866,  2776,
             2689};
         mismatches = 0;
      endfunction

      function reading_type convert_voltage(logic [15:0] voltage);
         reading_type r;
         int unsigned idx;
         int unsigned hi;
         int unsigned lo;
         int unsigned frac;
         logic [15:0] base;
         r.voltage     = voltage;
         r.temperature = '0;
         r.status      = tti_pkg::STATUS_OK;
         if (voltage > tti_pkg::VOLTAGE_LIMIT) begin
            r.status = tti_pkg::STATUS_HIGH;
            return r;
         end
         // first row at or below the input
         idx = 0;
         while (idx < USED_ENTRIES && volt_table[idx] > voltage) idx++;
         if (idx == 0) begin
            r.temperature = 16'(tti_pkg::FIRST_DEGREE * (1 << FRAC_BITS));
         end else if (idx >= USED_ENTRIES) begin
            r.status = tti_pkg::STATUS_LOW;
         end else begin
            hi   = volt_table[idx - 1];
            lo   = volt_table[idx];
            frac = ((hi - voltage) << FRAC_BITS) / (hi - lo);
            base = 16'((tti_pkg::FIRST_DEGREE + int'(idx) - 1) * (1 << FRAC_BITS));
            r.temperature = base + 16'(frac);
         end
         return r;
      endfunction

      function int unsigned pending();
         return pending_readings.size();
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_PRINTS) $display("mismatch: %s", msg);
      endtask

      task note_request(logic [15:0] voltage);
         pending_readings.push_back(convert_voltage(voltage));
      endtask

      task check_result(logic signed [15:0] temperature, logic [1:0] status);
         reading_type exp_r;
         if (pending_readings.size() == 0) begin
            report_mismatch($sformatf("result %0d/%0d with no request pending",
                                      temperature, status));
            return;
         end
         exp_r = pending_readings.pop_front();
         if (temperature !== exp_r.temperature)
            report_mismatch($sformatf("voltage %0d: temperature %0d, expected %0d",
                                      exp_r.voltage, temperature, exp_r.temperature));
         if (status !== exp_r.status)
            report_mismatch($sformatf("voltage %0d: status %0d, expected %0d",
                                      exp_r.voltage, status, exp_r.status));
      endtask
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_stall;
   logic [15:0]        req_voltage = '0;
   logic               rsp_valid;
   logic               rsp_stall   = 1'b0;
   logic signed [15:0] rsp_temperature;
   logic [1:0]         rsp_status;

   temperature_checker board;
   int unsigned        idle_cycles = 0;

   thermistor_table_interpolator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_voltage     (req_voltage),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_temperature (rsp_temperature),
      .rsp_status      (rsp_status)
   );

   always #4 clock = ~clock;

   // mostly short gaps, now and then a long one
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(50, 300);
   endfunction

   function automatic logic [15:0] pick_voltage();
      int unsigned r;
      int unsigned k;
      r = $urandom_range(0, 99);
      k = $urandom_range(0, tti_pkg::ROM_SIZE - 1);
      if (r < 60) return 16'($urandom_range(2689, 33000));
      if (r < 70) return 16'(int'(board.volt_table[k]) + int'($urandom_range(0, 2)) - 1);
      if (r < 80) return 16'($urandom_range(33001, 65535));
      if (r < 90) return 16'($urandom_range(0, 2688));
      return 16'($urandom);
   endfunction

   task automatic send_request(logic [15:0] voltage, int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_voltage <= voltage;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(voltage);
   endtask

   // result side: random stalls, one long hold-off early on
   initial begin
      int unsigned loops;
      int unsigned len;
      loops = 0;
      while (reset) @(posedge clock);
      forever begin
         loops++;
         len = (loops == 30) ? HOLD_CYCLES : gap_length();
         if (len > 0) begin
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         board.check_result(rsp_temperature, rsp_status);
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      logic [15:0] directed [$];
      board = new();
      directed = '{16'd0, 16'd65535, 16'd33000, 16'd33001, 16'd32999, 16'd31038,
                   16'd31039, 16'd31037, 16'd30915, 16'd30916, 16'd30914,
                   16'd20436, 16'd20000, 16'd9870, 16'd2776, 16'd2690, 16'd2689,
                   16'd2688, 16'd1, 16'd32768, 16'd16384, 16'd43690, 16'd21845,
                   16'd5000};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_request(directed[i], gap_length());
      for (int unsigned k = 0; k < RANDOM_REQS; k++) begin
         // back-to-back stretch in the middle
         send_request(pick_voltage(), (k >= 150 && k < 200) ? 0 : gap_length());
      end
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/tti_pkg.sv
hw/rtl/tti_rom.sv
hw/rtl/tti_div.sv
hw/rtl/thermistor_table_interpolator.sv
tb/sv/thermistor_table_interpolator_tb.sv
